// File: hdl/tpt_pkg.sv
// ----------------------------------------------------------------------------
// tpt_pkg - shared types and constants of the turbine power tracker
// Field widths, func and register codes, wind curve and ramp divider
// constants, and a small clamp helper used by the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpt_pkg;

    // default width of the held power register
    localparam int POWER_BITS_DEF = 20;

    // field and register widths
    localparam int PWR_W   = 20;
    localparam int SPD_W   = 16;
    localparam int MS_W    = 16;
    localparam int ALPHA_W = 17;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 2;
    localparam int FUNC_W  = 2;
    localparam int FILT_W  = 36;
    localparam int STEP_W  = 21;

    // shared multiplier operand widths
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 22;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // func codes
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PRESET = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    // register indexes
    localparam logic [IDX_W-1:0] REG_RATED = 2'd0;
    localparam logic [IDX_W-1:0] REG_MIN   = 2'd1;
    localparam logic [IDX_W-1:0] REG_RAMP  = 2'd2;
    localparam logic [IDX_W-1:0] REG_ALPHA = 2'd3;

    // alpha reset, 0.7 in Q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd45875;

    // wind curve in Q8.8 m/s: cut-in 3, knee 11, cut-out 25
    localparam logic [SPD_W-1:0] V_CUT_IN  = 16'd768;
    localparam logic [SPD_W-1:0] V_KNEE    = 16'd2816;
    localparam logic [SPD_W-1:0] V_CUT_OUT = 16'd6400;

    // divide by 60000 = shift by 5, then divide by 1875 via reciprocal
    localparam int               RAMP_PRE_SHIFT = 5;
    localparam logic [10:0]      RAMP_DIV       = 11'd1875;
    localparam logic [MUL_B_W-1:0] RAMP_RECIP   = 22'd2290649;  // floor(2^32 / 1875)

    // rounding offsets of the low-pass step
    localparam logic [52:0] RND_UP = 53'd32768;
    localparam logic [52:0] RND_DN = 53'd32767;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SPD_W-1:0]  wind_vel;
        logic [MS_W-1:0]   step_ms;
        logic [PWR_W-1:0]  power_value;
        logic              available;
    } item_t;

    typedef struct packed {
        logic [PWR_W-1:0]   nominal_power;
        logic [PWR_W-1:0]   min_power;
        logic [PWR_W-1:0]   ramp_per_minute;
        logic [ALPHA_W-1:0] filter_alpha;
    } cfg_t;

    typedef struct packed {
        logic idle;
        logic done;
    } stat_t;

    // max(lo, min(x, hi)); lo wins when lo > hi
    function automatic logic [21:0] clamp_p(input logic [21:0] x,
                                            input logic [21:0] lo,
                                            input logic [21:0] hi);
        logic [21:0] t;
        t = (x < hi) ? x : hi;
        return (t > lo) ? t : lo;
    endfunction

endpackage

`default_nettype wire

// File: hdl/tpt_mul.sv
// ----------------------------------------------------------------------------
// tpt_mul - shared multiplier with registered product
// One 36 x 22 unsigned multiply per cycle; the product is registered and
// appears in the cycle after the operands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpt_mul (
    input  wire logic                        clk,
    input  wire logic [tpt_pkg::MUL_A_W-1:0] a,
    input  wire logic [tpt_pkg::MUL_B_W-1:0] b,
    output logic      [tpt_pkg::MUL_P_W-1:0] prod
);

    logic [tpt_pkg::MUL_P_W-1:0] prod_reg;
    logic [tpt_pkg::MUL_P_W-1:0] prod_next;

    // unsigned product
    always_comb
    begin
        prod_next = tpt_pkg::MUL_P_W'(a) * tpt_pkg::MUL_P_W'(b);
    end

    // product register
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: hdl/tpt_ctrl.sv
// ----------------------------------------------------------------------------
// tpt_ctrl - sequencer and datapath of the power tracker
// Walks one tick item through wind curve, ramp step, clamps and low-pass
// filter, issuing every product to the shared multiplier, applies preset
// and clear, and keeps the held power and filter state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpt_ctrl #(
    parameter int POWER_BITS = tpt_pkg::POWER_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      take,
    input  wire tpt_pkg::item_t            item,
    input  wire tpt_pkg::cfg_t             cfg,
    output tpt_pkg::stat_t                 stat,
    output logic [tpt_pkg::PWR_W-1:0]      result
);

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DD   = 4'd1;
    localparam logic [3:0] S_WP   = 4'd2;
    localparam logic [3:0] S_RM   = 4'd3;
    localparam logic [3:0] S_Q0   = 4'd4;
    localparam logic [3:0] S_QM   = 4'd5;
    localparam logic [3:0] S_STEP = 4'd6;
    localparam logic [3:0] S_X    = 4'd7;
    localparam logic [3:0] S_DIFF = 4'd8;
    localparam logic [3:0] S_MUL  = 4'd9;
    localparam logic [3:0] S_LPW  = 4'd10;
    localparam logic [3:0] S_HELD = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    localparam int HW = (POWER_BITS > tpt_pkg::PWR_W) ? POWER_BITS : tpt_pkg::PWR_W;
    // saturation ceiling: power maximum, never above the 20-bit field
    localparam logic [21:0] CAP = (POWER_BITS < tpt_pkg::PWR_W) ?
                                  22'((64'd1 << POWER_BITS) - 64'd1) : 22'h0FFFFF;

    function automatic logic [tpt_pkg::PWR_W-1:0] sat_p(input logic [21:0] v);
        return (v > CAP) ? CAP[tpt_pkg::PWR_W-1:0] : v[tpt_pkg::PWR_W-1:0];
    endfunction

    // control and model state
    logic [3:0]                       state_reg,  state_next;
    logic [POWER_BITS-1:0]            held_reg,   held_next;
    logic [tpt_pkg::FILT_W-1:0]       filt_reg,   filt_next;
    logic                             primed_reg, primed_next;

    // per-item working registers
    tpt_pkg::item_t                   item_reg,   item_next;
    logic [tpt_pkg::PWR_W-1:0]        lim_reg,    lim_next;
    logic [30:0]                      pp_reg,     pp_next;
    logic [tpt_pkg::STEP_W-1:0]       q0_reg,     q0_next;
    logic [tpt_pkg::STEP_W-1:0]       step_reg,   step_next;
    logic [tpt_pkg::PWR_W-1:0]        target_reg, target_next;
    logic [tpt_pkg::PWR_W-1:0]        x_reg,      x_next;
    logic [tpt_pkg::FILT_W-1:0]       diff_reg,   diff_next;
    logic                             dn_reg,     dn_next;

    // multiplier interface
    logic [tpt_pkg::MUL_A_W-1:0]      mul_a;
    logic [tpt_pkg::MUL_B_W-1:0]      mul_b;
    logic [tpt_pkg::MUL_P_W-1:0]      prod;

    // helpers
    logic [HW-1:0]                    held_w;
    logic [tpt_pkg::PWR_W-1:0]        held20;
    logic [tpt_pkg::SPD_W-1:0]        d_full;
    logic [tpt_pkg::PWR_W-1:0]        x_pre;
    logic [tpt_pkg::PWR_W-1:0]        p_wind;
    logic [30:0]                      rem;
    logic [21:0]                      lo_b;
    logic [21:0]                      hi_b;
    logic [tpt_pkg::PWR_W-1:0]        x_tick;
    logic [tpt_pkg::FILT_W-1:0]       xq;
    logic [tpt_pkg::FILT_W-1:0]       inc_up;
    logic [tpt_pkg::FILT_W-1:0]       inc_dn;
    logic [36:0]                      rnd;

    tpt_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign held_w = HW'(held_reg);
    assign held20 = held_w[tpt_pkg::PWR_W-1:0];
    assign d_full = item_reg.wind_vel - tpt_pkg::V_CUT_IN;

    // preset value from the incoming beat
    assign x_pre = sat_p(tpt_pkg::clamp_p(22'(item.power_value), 22'(cfg.min_power),
                                          22'(cfg.nominal_power)));

    // wind curve from the rated * d^2 product
    always_comb
    begin
        if ((item_reg.wind_vel < tpt_pkg::V_CUT_IN) ||
            (item_reg.wind_vel > tpt_pkg::V_CUT_OUT))
        begin
            p_wind = '0;
        end
        else if (item_reg.wind_vel < tpt_pkg::V_KNEE)
        begin
            p_wind = prod[41:22];
        end
        else
        begin
            p_wind = cfg.nominal_power;
        end
    end

    // ramp window around held power and the ramp-limited sample
    assign rem    = pp_reg - prod[30:0];
    assign lo_b   = (22'(held20) > 22'(step_reg)) ? (22'(held20) - 22'(step_reg)) : 22'd0;
    assign hi_b   = 22'(held20) + 22'(step_reg);
    assign x_tick = sat_p(tpt_pkg::clamp_p(22'(target_reg), lo_b, hi_b));

    // low-pass increments, rounded to nearest with halves rounding the result up
    assign xq     = {x_reg, 16'd0};
    assign inc_up = tpt_pkg::FILT_W'(({1'b0, prod[51:0]} + tpt_pkg::RND_UP) >> 16);
    assign inc_dn = tpt_pkg::FILT_W'(({1'b0, prod[51:0]} + tpt_pkg::RND_DN) >> 16);
    assign rnd    = {1'b0, filt_reg} + 37'd32768;

    // operand select for the shared multiplier
    always_comb
    begin
        case (state_reg)
            S_DD:
            begin
                mul_a = tpt_pkg::MUL_A_W'(d_full[10:0]);
                mul_b = tpt_pkg::MUL_B_W'(d_full[10:0]);
            end
            S_WP:
            begin
                mul_a = tpt_pkg::MUL_A_W'(cfg.nominal_power);
                mul_b = prod[21:0];
            end
            S_RM:
            begin
                mul_a = tpt_pkg::MUL_A_W'(cfg.ramp_per_minute);
                mul_b = tpt_pkg::MUL_B_W'(item_reg.step_ms);
            end
            S_Q0:
            begin
                mul_a = tpt_pkg::MUL_A_W'(prod[35:tpt_pkg::RAMP_PRE_SHIFT]);
                mul_b = tpt_pkg::RAMP_RECIP;
            end
            S_QM:
            begin
                mul_a = tpt_pkg::MUL_A_W'(prod[52:32]);
                mul_b = tpt_pkg::MUL_B_W'(tpt_pkg::RAMP_DIV);
            end
            S_MUL:
            begin
                mul_a = diff_reg;
                mul_b = tpt_pkg::MUL_B_W'(cfg.filter_alpha[15:0]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        filt_next   = filt_reg;
        primed_next = primed_reg;
        item_next   = item_reg;
        lim_next    = lim_reg;
        pp_next     = pp_reg;
        q0_next     = q0_reg;
        step_next   = step_reg;
        target_next = target_reg;
        x_next      = x_reg;
        diff_next   = diff_reg;
        dn_next     = dn_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next  = item;
                    state_next = S_DONE;
                    case (item.func)
                        tpt_pkg::FUNC_TICK:
                        begin
                            if (item.available)
                            begin
                                state_next = S_DD;
                            end
                            else
                            begin
                                held_next = '0;
                            end
                        end
                        tpt_pkg::FUNC_PRESET:
                        begin
                            held_next   = POWER_BITS'(x_pre);
                            filt_next   = {x_pre, 16'd0};
                            primed_next = 1'b1;
                        end
                        tpt_pkg::FUNC_CLEAR:
                        begin
                            held_next   = '0;
                            filt_next   = '0;
                            primed_next = 1'b0;
                        end
                        default:
                        begin
                            // unused code: held power and filter unchanged
                        end
                    endcase
                end
            end
            S_DD:
            begin
                state_next = S_WP;
            end
            S_WP:
            begin
                state_next = S_RM;
            end
            S_RM:
            begin
                lim_next   = tpt_pkg::PWR_W'(tpt_pkg::clamp_p(22'(p_wind),
                                                              22'(cfg.min_power),
                                                              22'(cfg.nominal_power)));
                state_next = S_Q0;
            end
            S_Q0:
            begin
                pp_next    = prod[35:tpt_pkg::RAMP_PRE_SHIFT];
                state_next = S_QM;
            end
            S_QM:
            begin
                q0_next    = prod[52:32];
                state_next = S_STEP;
            end
            S_STEP:
            begin
                // reciprocal quotient is low by at most one
                step_next   = q0_reg + tpt_pkg::STEP_W'(rem >= 31'(tpt_pkg::RAMP_DIV));
                target_next = tpt_pkg::PWR_W'(tpt_pkg::clamp_p(22'(item_reg.power_value),
                                                               22'(cfg.min_power),
                                                               22'(lim_reg)));
                state_next  = S_X;
            end
            S_X:
            begin
                x_next = x_tick;
                if (!primed_reg || cfg.filter_alpha[16])
                begin
                    // first sample or unity weight passes straight through
                    filt_next   = {x_tick, 16'd0};
                    primed_next = 1'b1;
                    held_next   = POWER_BITS'(x_tick);
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
            begin
                dn_next    = xq < filt_reg;
                diff_next  = (xq < filt_reg) ? (filt_reg - xq) : (xq - filt_reg);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_LPW;
            end
            S_LPW:
            begin
                filt_next  = dn_reg ? (filt_reg - inc_dn) : (filt_reg + inc_up);
                state_next = S_HELD;
            end
            S_HELD:
            begin
                held_next  = POWER_BITS'(sat_p(22'(rnd[36:16])));
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and model state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            held_reg   <= '0;
            filt_reg   <= '0;
            primed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            held_reg   <= held_next;
            filt_reg   <= filt_next;
            primed_reg <= primed_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        lim_reg    <= lim_next;
        pp_reg     <= pp_next;
        q0_reg     <= q0_next;
        step_reg   <= step_next;
        target_reg <= target_next;
        x_reg      <= x_next;
        diff_reg   <= diff_next;
        dn_reg     <= dn_next;
    end

    assign stat.idle = (state_reg == S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign result    = held20;

endmodule

`default_nettype wire

// File: hdl/turbine_power_tracker_top.sv
// ----------------------------------------------------------------------------
// turbine_power_tracker_top - wind turbine power set-point tracker
// Wind-limited power command with ramp limit and first-order low-pass,
// one result beat per item beat, configuration by a plain write port.
// ----------------------------------------------------------------------------
//  channel   signals                                           dir
//  item      item_valid/item_ready, func, wind_vel,            in
//            step_ms, power_value, available
//  result    result_valid/result_ready, power_out              out
//  config    cfg_wr_en, cfg_index, cfg_data (no wait)          in
//
//  tick: wind curve, ramp step and clamps, then the filter steps unless
//  the sample passes straight through (unprimed filter or unity weight);
//  wind curve, ramp divide and filter share the one multiplier; preset,
//  clear, unavailable tick and unused code go straight to done
//  one item is in work at a time; item_ready is high only while idle, so the
//  next beat is taken no earlier than the cycle after the result moves to the output register
//  a finished result waits in the output register; a next item may start
//  while it waits, and then holds in its last state until the register frees
//  reset clears state, sets filter_alpha to 0.7 and the other config registers to 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module turbine_power_tracker_top #(
    parameter int POWER_BITS = tpt_pkg::POWER_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire logic [tpt_pkg::FUNC_W-1:0]    func,
    input  wire logic [tpt_pkg::SPD_W-1:0]     wind_vel,
    input  wire logic [tpt_pkg::MS_W-1:0]      step_ms,
    input  wire logic [tpt_pkg::PWR_W-1:0]     power_value,
    input  wire logic                          available,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output logic [tpt_pkg::PWR_W-1:0]          power_out,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tpt_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [tpt_pkg::CFG_W-1:0]     cfg_data
);

    tpt_pkg::cfg_t                  cfg_reg, cfg_next;
    logic                           rvalid_reg, rvalid_next;
    logic [tpt_pkg::PWR_W-1:0]      pout_reg, pout_next;

    tpt_pkg::item_t                 item;
    tpt_pkg::stat_t                 stat;
    logic [tpt_pkg::PWR_W-1:0]      result;
    logic                           start;
    logic                           take;

    assign item.func        = func;
    assign item.wind_vel    = wind_vel;
    assign item.step_ms     = step_ms;
    assign item.power_value = power_value;
    assign item.available   = available;

    // item beat handshake
    assign item_ready = stat.idle;
    assign start      = item_valid && item_ready;

    // result moves out when the output register is free or being drained
    assign take = stat.done && (!rvalid_reg || result_ready);

    tpt_ctrl #(
        .POWER_BITS (POWER_BITS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .take   (take),
        .item   (item),
        .cfg    (cfg_reg),
        .stat   (stat),
        .result (result)
    );

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                tpt_pkg::REG_RATED: cfg_next.nominal_power   = cfg_data;
                tpt_pkg::REG_MIN:   cfg_next.min_power       = cfg_data;
                tpt_pkg::REG_RAMP:  cfg_next.ramp_per_minute = cfg_data;
                tpt_pkg::REG_ALPHA: cfg_next.filter_alpha    = cfg_data[tpt_pkg::ALPHA_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // output register
    always_comb
    begin
        rvalid_next = rvalid_reg;
        pout_next   = pout_reg;
        if (take)
        begin
            rvalid_next = 1'b1;
            pout_next   = result;
        end
        else if (result_ready)
        begin
            rvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.nominal_power   <= '0;
            cfg_reg.min_power       <= '0;
            cfg_reg.ramp_per_minute <= '0;
            cfg_reg.filter_alpha    <= tpt_pkg::ALPHA_RST;
            rvalid_reg              <= 1'b0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            rvalid_reg <= rvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pout_reg <= pout_next;
    end

    assign result_valid = rvalid_reg;
    assign power_out    = pout_reg;

endmodule

`default_nettype wire

// File: hdl/tpt_checker.sv
// ----------------------------------------------------------------------------
// tpt_checker - port-level checks of the power tracker
// Watches the item and result beats and checks handshake, one-at-a-time
// operation and beat balance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpt_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      item_valid,
    input wire logic                      item_ready,
    input wire logic                      result_valid,
    input wire logic                      result_ready,
    input wire logic [tpt_pkg::PWR_W-1:0] power_out
);

    logic [1:0] pend_reg, pend_next;

    // items accepted whose result beat has not gone out
    always_comb
    begin
        pend_next = pend_reg;
        if ((item_valid && item_ready) && !(result_valid && result_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(item_valid && item_ready) && (result_valid && result_ready))
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 2'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // result beat holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result beat dropped before it was taken");

    // stalled result keeps its value
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(power_out))
        else $error("power_out changed while stalled");

    // one item at a time: busy right after an item beat
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item accepted while previous item still in work");

    // no more than one item in work plus one result waiting
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("too many items outstanding");

    // no result beat without an item behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> pend_reg != 2'd0)
        else $error("result beat with no item outstanding");

endmodule

bind turbine_power_tracker_top tpt_checker u_tpt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .power_out    (power_out)
);

`default_nettype wire

// File: sim/tb_turbine_power_tracker_top.sv
// ----------------------------------------------------------------------------
// tb_turbine_power_tracker_top - self-checking bench of the power tracker
// Walks a table of directed items, then phases of random ticks, presets and
// clears under changing register settings. Every result beat is compared
// with its table value or a bench-side model of wind curve, ramp and low-pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_turbine_power_tracker_top;

    localparam logic [tpt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam longint unsigned   MS_PER_MIN  = 60000;
    localparam longint unsigned   ALPHA_ONE   = 65536;
    localparam longint unsigned   POWER_MAX   = (64'd1 << tpt_pkg::POWER_BITS_DEF) - 1;
    localparam longint unsigned   PWR_FULL    = 64'hFFFFF;
    localparam int                PHASES      = 8;
    localparam int                PHASE_ITEMS = 69;

    // one row of the directed table: a register write or an item
    typedef struct packed {
        logic                      is_cfg;
        logic [tpt_pkg::IDX_W-1:0] reg_idx;
        logic [tpt_pkg::CFG_W-1:0] reg_val;
        tpt_pkg::item_t            beat;
        logic                      typed;
        logic [tpt_pkg::PWR_W-1:0] want;
    } row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         item_valid;
    logic                         item_ready;
    logic [tpt_pkg::FUNC_W-1:0]   func;
    logic [tpt_pkg::SPD_W-1:0]    wind_vel;
    logic [tpt_pkg::MS_W-1:0]     step_ms;
    logic [tpt_pkg::PWR_W-1:0]    power_value;
    logic                         available;
    logic                         result_valid;
    logic                         result_ready = 1'b0;
    logic [tpt_pkg::PWR_W-1:0]    power_out;
    logic                         cfg_wr_en;
    logic [tpt_pkg::IDX_W-1:0]    cfg_index;
    logic [tpt_pkg::CFG_W-1:0]    cfg_data;

    // model copy of registers and state
    logic [tpt_pkg::PWR_W-1:0]          cf_rated;
    logic [tpt_pkg::PWR_W-1:0]          cf_min;
    logic [tpt_pkg::PWR_W-1:0]          cf_ramp;
    logic [tpt_pkg::ALPHA_W-1:0]        cf_alpha;
    logic [tpt_pkg::POWER_BITS_DEF-1:0] held_q;
    logic [tpt_pkg::FILT_W-1:0]         filt_q;
    logic                               primed_q;

    logic [tpt_pkg::PWR_W-1:0] expected_power[$];
    row_t                      directed_rows[$];
    logic [tpt_pkg::PWR_W-1:0] head_power;
    int                        fail_count = 0;
    int unsigned               rx_hold = 0;
    bit                        send_steady;
    bit                        take_steady;

    turbine_power_tracker_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .wind_vel     (wind_vel),
        .step_ms      (step_ms),
        .power_value  (power_value),
        .available    (available),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .power_out    (power_out),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // hard stop
    initial
    begin
        #10ms;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // model of the tracker
    // ------------------------------------------------------------------

    // max(lo, min(x, hi)), lo wins when the limits cross
    function automatic longint unsigned bound(input longint unsigned x,
                                              input longint unsigned lo,
                                              input longint unsigned hi);
        longint unsigned t;
        t = (x < hi) ? x : hi;
        return (t > lo) ? t : lo;
    endfunction

    function automatic longint unsigned sat_power(input longint unsigned x);
        return (x > POWER_MAX) ? POWER_MAX : x;
    endfunction

    // power the wind allows, limited to [min, rated]
    function automatic longint unsigned wind_allowance(input logic [tpt_pkg::SPD_W-1:0] v);
        longint unsigned p;
        longint unsigned d;
        if (v < tpt_pkg::V_CUT_IN || v > tpt_pkg::V_CUT_OUT)
            p = 0;
        else if (v < tpt_pkg::V_KNEE)
        begin
            d = v - tpt_pkg::V_CUT_IN;
            p = (longint'(cf_rated) * d * d) >> 22;
        end
        else
            p = cf_rated;
        return bound(p, cf_min, cf_rated);
    endfunction

    // first-order low-pass on Q.16 values, halves round up
    function automatic longint unsigned smooth(input longint unsigned x,
                                               input longint unsigned y);
        longint unsigned a;
        a = (cf_alpha > ALPHA_ONE) ? ALPHA_ONE : cf_alpha;
        if (a == ALPHA_ONE)
            return x;
        if (x >= y)
            return y + ((a * (x - y) + 32768) >> 16);
        return y - ((a * (y - x) + 32767) >> 16);
    endfunction

    // advance the model by one item, return the power it reports
    function automatic logic [tpt_pkg::PWR_W-1:0] track_power(input tpt_pkg::item_t it);
        longint unsigned lim;
        longint unsigned target;
        longint unsigned stride;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned x;
        longint unsigned y;
        case (it.func)
            tpt_pkg::FUNC_TICK:
            begin
                if (!it.available)
                    held_q = '0;
                else
                begin
                    lim    = wind_allowance(it.wind_vel);
                    target = bound(it.power_value, cf_min, lim);
                    stride = (longint'(cf_ramp) * it.step_ms) / MS_PER_MIN;
                    lo     = (held_q > stride) ? held_q - stride : 0;
                    hi     = longint'(held_q) + stride;
                    x      = sat_power(bound(target, lo, hi));
                    if (!primed_q)
                    begin
                        filt_q   = tpt_pkg::FILT_W'(x << 16);
                        primed_q = 1'b1;
                    end
                    else
                    begin
                        y      = filt_q;
                        filt_q = tpt_pkg::FILT_W'(smooth(x << 16, y));
                    end
                    y      = filt_q;
                    held_q = tpt_pkg::POWER_BITS_DEF'(sat_power((y + 32768) >> 16));
                end
            end
            tpt_pkg::FUNC_PRESET:
            begin
                held_q   = tpt_pkg::POWER_BITS_DEF'(sat_power(bound(it.power_value,
                                                                    cf_min, cf_rated)));
                filt_q   = tpt_pkg::FILT_W'(longint'(held_q) << 16);
                primed_q = 1'b1;
            end
            tpt_pkg::FUNC_CLEAR:
            begin
                held_q   = '0;
                filt_q   = '0;
                primed_q = 1'b0;
            end
            default: ;
        endcase
        return held_q[tpt_pkg::PWR_W-1:0];
    endfunction

    function automatic void apply_setting(input logic [tpt_pkg::IDX_W-1:0] idx,
                                          input logic [tpt_pkg::CFG_W-1:0] val);
        case (idx)
            tpt_pkg::REG_RATED: cf_rated = val[tpt_pkg::PWR_W-1:0];
            tpt_pkg::REG_MIN:   cf_min   = val[tpt_pkg::PWR_W-1:0];
            tpt_pkg::REG_RAMP:  cf_ramp  = val[tpt_pkg::PWR_W-1:0];
            tpt_pkg::REG_ALPHA: cf_alpha = val[tpt_pkg::ALPHA_W-1:0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap(input bit steady);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic tpt_pkg::item_t make_item();
        tpt_pkg::item_t it;
        int unsigned r;
        longint unsigned pv_top;
        r = $urandom_range(0, 99);
        if (r < 82)
            it.func = tpt_pkg::FUNC_TICK;
        else if (r < 90)
            it.func = tpt_pkg::FUNC_PRESET;
        else if (r < 96)
            it.func = tpt_pkg::FUNC_CLEAR;
        else
            it.func = FUNC_UNUSED;
        // wind: mostly on the curve, some at its corners, some below cut-in, some anywhere
        r = $urandom_range(0, 99);
        if (r < 65)
            it.wind_vel = tpt_pkg::SPD_W'($urandom_range(700, 6500));
        else if (r < 77)
        begin
            case ($urandom_range(0, 8))
                0: it.wind_vel = tpt_pkg::V_CUT_IN - 16'd1;
                1: it.wind_vel = tpt_pkg::V_CUT_IN;
                2: it.wind_vel = tpt_pkg::V_CUT_IN + 16'd1;
                3: it.wind_vel = tpt_pkg::V_KNEE - 16'd1;
                4: it.wind_vel = tpt_pkg::V_KNEE;
                5: it.wind_vel = tpt_pkg::V_KNEE + 16'd1;
                6: it.wind_vel = tpt_pkg::V_CUT_OUT - 16'd1;
                7: it.wind_vel = tpt_pkg::V_CUT_OUT;
                default: it.wind_vel = tpt_pkg::V_CUT_OUT + 16'd1;
            endcase
        end
        else if (r < 87)
            it.wind_vel = tpt_pkg::SPD_W'($urandom_range(0, 767));
        else
            it.wind_vel = tpt_pkg::SPD_W'($urandom_range(0, 65535));
        r = $urandom_range(0, 99);
        if (r < 60)
            it.step_ms = tpt_pkg::MS_W'($urandom_range(0, 1000));
        else if (r < 85)
            it.step_ms = tpt_pkg::MS_W'($urandom_range(1000, 10000));
        else
            it.step_ms = tpt_pkg::MS_W'($urandom_range(0, 65535));
        // command mostly around the rated range
        pv_top = longint'(cf_rated) + cf_rated / 8;
        if (pv_top > PWR_FULL)
            pv_top = PWR_FULL;
        if ($urandom_range(0, 99) < 70)
            it.power_value = tpt_pkg::PWR_W'($urandom_range(0, int'(pv_top)));
        else
            it.power_value = tpt_pkg::PWR_W'($urandom_range(0, int'(PWR_FULL)));
        it.available = ($urandom_range(0, 99) < 90);
        return it;
    endfunction

    function automatic void add_item(input logic [tpt_pkg::FUNC_W-1:0] f,
                                     input logic [tpt_pkg::SPD_W-1:0] v,
                                     input logic [tpt_pkg::MS_W-1:0] ms,
                                     input logic [tpt_pkg::PWR_W-1:0] pv,
                                     input logic av,
                                     input logic typed,
                                     input logic [tpt_pkg::PWR_W-1:0] want);
        row_t r;
        r = '0;
        r.beat.func        = f;
        r.beat.wind_vel    = v;
        r.beat.step_ms     = ms;
        r.beat.power_value = pv;
        r.beat.available   = av;
        r.typed            = typed;
        r.want             = want;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [tpt_pkg::IDX_W-1:0] idx,
                                    input logic [tpt_pkg::CFG_W-1:0] val);
        row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        directed_rows.push_back(r);
    endfunction

    // one item beat; expectation is queued at the accepting edge
    task automatic push_item(input tpt_pkg::item_t it, input logic typed,
                             input logic [tpt_pkg::PWR_W-1:0] want);
        int unsigned gap;
        logic [tpt_pkg::PWR_W-1:0] model_val;
        gap = pick_gap(send_steady);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid  <= 1'b1;
        func        <= it.func;
        wind_vel    <= it.wind_vel;
        step_ms     <= it.step_ms;
        power_value <= it.power_value;
        available   <= it.available;
        do
            @(negedge clk);
        while (!item_ready);
        @(posedge clk);
        model_val = track_power(it);
        expected_power.push_back(typed ? want : model_val);
    endtask

    // hold off items until every result is back and the block is idle
    task automatic wait_idle();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_power.size() != 0 || !item_ready);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [tpt_pkg::IDX_W-1:0] idx,
                             input logic [tpt_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_setting(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // random register set for one phase, extremes included
    task automatic pick_settings();
        int unsigned r;
        logic [tpt_pkg::CFG_W-1:0] val;
        r = $urandom_range(0, 99);
        if (r < 15)
            val = tpt_pkg::CFG_W'(PWR_FULL);
        else if (r < 20)
            val = '0;
        else
            val = tpt_pkg::CFG_W'($urandom_range(1000, int'(PWR_FULL)));
        write_reg(tpt_pkg::REG_RATED, val);
        r = $urandom_range(0, 99);
        if (r < 70)
            val = tpt_pkg::CFG_W'($urandom_range(0, int'(cf_rated / 4)));
        else if (r < 85)
            val = '0;
        else
            val = tpt_pkg::CFG_W'($urandom_range(0, int'(PWR_FULL)));
        write_reg(tpt_pkg::REG_MIN, val);
        r = $urandom_range(0, 99);
        if (r < 10)
            val = '0;
        else if (r < 20)
            val = tpt_pkg::CFG_W'(PWR_FULL);
        else
            val = tpt_pkg::CFG_W'($urandom_range(1, 200000));
        write_reg(tpt_pkg::REG_RAMP, val);
        r = $urandom_range(0, 99);
        if (r < 10)
            val = '0;
        else if (r < 20)
            val = tpt_pkg::CFG_W'(ALPHA_ONE);
        else if (r < 25)
            val = tpt_pkg::CFG_W'($urandom_range(int'(ALPHA_ONE) + 1, int'(PWR_FULL)));
        else
            val = tpt_pkg::CFG_W'($urandom_range(1, int'(ALPHA_ONE) - 1));
        write_reg(tpt_pkg::REG_ALPHA, val);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // ready with random stall stretches
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold      <= rx_hold - 1;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            if (!take_steady && $urandom_range(0, 99) < 25)
                rx_hold <= pick_gap(1'b0);
        end
    end

    // a beat is taken at the next edge when valid and ready are high here
    always @(negedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_power.size() == 0)
            begin
                $error("power_out beat with nothing expected: actual %0d", power_out);
                fail_count++;
            end
            else
            begin
                head_power = expected_power.pop_front();
                if (power_out !== head_power)
                begin
                    $error("power_out mismatch: expected %0d, actual %0d",
                           head_power, power_out);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        item_valid   = 1'b0;
        func         = tpt_pkg::FUNC_TICK;
        wind_vel     = '0;
        step_ms      = '0;
        power_value  = '0;
        available    = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = tpt_pkg::REG_RATED;
        cfg_data     = '0;
        send_steady  = 1'b0;
        take_steady  = 1'b0;
        cf_rated     = '0;
        cf_min       = '0;
        cf_ramp      = '0;
        cf_alpha     = tpt_pkg::ALPHA_RST;
        held_q       = '0;
        filt_q       = '0;
        primed_q     = 1'b0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rated power still zero after reset, so nothing is allowed
        add_item(tpt_pkg::FUNC_TICK, 16'd2000, 16'd1000, 20'd500, 1'b1, 1'b1, 20'd0);
        add_cfg(tpt_pkg::REG_RATED, 20'd1000000);
        // ramp of 60000 per minute moves one unit per millisecond
        add_cfg(tpt_pkg::REG_RAMP, 20'd60000);
        add_item(tpt_pkg::FUNC_PRESET, 16'd0, 16'd0, 20'hFFFFF, 1'b1, 1'b1, 20'd1000000);
        add_item(tpt_pkg::FUNC_PRESET, 16'hFFFF, 16'hFFFF, 20'd0, 1'b0, 1'b1, 20'd0);
        add_item(tpt_pkg::FUNC_PRESET, 16'd3000, 16'd10, 20'd400000, 1'b1, 1'b1,
                 20'd400000);
        // unavailable tick drops power, filter keeps its value
        add_item(tpt_pkg::FUNC_TICK, 16'd3000, 16'd100, 20'd400000, 1'b0, 1'b1, 20'd0);
        // wind curve corners with full command and long steps
        add_item(tpt_pkg::FUNC_TICK, 16'd0, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, tpt_pkg::V_CUT_IN, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, tpt_pkg::V_KNEE - 16'd1, 16'hFFFF, 20'hFFFFF, 1'b1,
                 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, tpt_pkg::V_KNEE, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, tpt_pkg::V_CUT_OUT, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b0,
                 '0);
        add_item(tpt_pkg::FUNC_TICK, tpt_pkg::V_CUT_OUT + 16'd1, 16'hFFFF, 20'hFFFFF, 1'b1,
                 1'b0, '0);
        add_item(tpt_pkg::FUNC_CLEAR, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1, 20'd0);
        // first tick after clear primes the filter
        add_item(tpt_pkg::FUNC_TICK, 16'd4000, 16'hFFFF, 20'd300000, 1'b1, 1'b0, '0);
        // unused code leaves everything alone
        add_item(FUNC_UNUSED, 16'd4000, 16'd5000, 20'd900000, 1'b1, 1'b0, '0);
        add_cfg(tpt_pkg::REG_ALPHA, 20'd65536);
        add_item(tpt_pkg::FUNC_TICK, 16'd4000, 16'd20000, 20'd600000, 1'b1, 1'b0, '0);
        add_cfg(tpt_pkg::REG_ALPHA, 20'd0);
        add_item(tpt_pkg::FUNC_TICK, 16'd4000, 16'd20000, 20'd100000, 1'b1, 1'b0, '0);
        // alpha beyond one behaves as one
        add_cfg(tpt_pkg::REG_ALPHA, 20'd131071);
        add_item(tpt_pkg::FUNC_TICK, 16'd4000, 16'd20000, 20'd100000, 1'b1, 1'b0, '0);
        // min above rated: every clamp gives min
        add_cfg(tpt_pkg::REG_MIN, 20'hFFFFF);
        add_item(tpt_pkg::FUNC_PRESET, 16'd0, 16'd0, 20'd0, 1'b1, 1'b1, 20'hFFFFF);
        add_item(tpt_pkg::FUNC_TICK, 16'd0, 16'd5000, 20'd0, 1'b1, 1'b0, '0);
        add_cfg(tpt_pkg::REG_MIN, 20'd0);
        add_cfg(tpt_pkg::REG_RAMP, 20'hFFFFF);
        add_cfg(tpt_pkg::REG_ALPHA, 20'd45875);
        add_item(tpt_pkg::FUNC_TICK, 16'd2000, 16'hFFFF, 20'd700000, 1'b1, 1'b0, '0);
        add_item(tpt_pkg::FUNC_TICK, 16'd2000, 16'd0, 20'd0, 1'b1, 1'b0, '0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                push_item(directed_rows[i].beat, directed_rows[i].typed,
                          directed_rows[i].want);
        end

        // random phases, each under fresh settings
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            pick_settings();
            send_steady = ($urandom_range(0, 3) == 0);
            take_steady = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                push_item(make_item(), 1'b0, '0);
        end

        wait_idle();
        repeat (16) @(posedge clk);
        if (expected_power.size() != 0)
            $error("power_out beats still expected at end: %0d", expected_power.size());
        if (fail_count == 0 && expected_power.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
